// ===== src/gss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gss_pkg;

    localparam int GRID_SIZE = 16;
    localparam int COL_W     = 4;
    localparam int LEN_W     = 5;
    localparam int MODE_W    = 3;
    localparam int OP_W      = 3;
    localparam int RND_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    localparam logic [OP_W-1:0] OP_CLOCK = 3'd0;
    localparam logic [OP_W-1:0] OP_RESET = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
    localparam logic [OP_W-1:0] OP_ROT   = 3'd3;
    localparam logic [OP_W-1:0] OP_FLIP  = 3'd4;
    localparam logic [OP_W-1:0] OP_SHIFT = 3'd5;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd6;

    localparam logic [MODE_W-1:0] MODE_FWD  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BWD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PP_A = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PP_B = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RND  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    typedef logic [GRID_SIZE-1:0] col_t;

    typedef struct packed {
        logic [COL_W-1:0]  window_start;
        logic [LEN_W-1:0]  window_length;
        logic [MODE_W-1:0] play_mode;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-1:0] position;
        logic             end_of_cycle;
        logic             reset_pending;
    } ph_res_t;

endpackage

`default_nettype wire

// ===== src/grid_step_sequencer.sv =====
// Grid step sequencer: 16x16 pattern grid plus a playhead over a column window.
// Input channel (s_valid/s_ready): one event per beat - clock, reset, clear,
// rotate right, flip vertical, shift up or write cell.
// Output channel (m_valid/m_ready): exactly one result beat per event, carrying
// playhead position, end-of-cycle flag, the bottom-up row mask of the current
// column and the pending-restart flag, all taken after the event.
// Config channel (cfg_valid/cfg_ready): index 0 window start, 1 window length,
// 2 play mode; other indices are dropped. cfg_ready is always high; write only
// while no event is in flight.
// Path from input beat to result beat: input register, then the event is applied
// and the result register loaded together.
// Throughput: one event per cycle while the receiver keeps up (m_ready high).
// A stalled receiver holds the result register; one more event waits in the
// input register, then s_ready drops.
// Reset (aresetn low, synchronous): grid cleared, playhead 0, restart pending,
// window 0..15, forward mode, both channels empty.
`timescale 1ns / 1ps
`default_nettype none

module grid_step_sequencer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [gss_pkg::OP_W-1:0]      s_opcode,
    input  wire logic [gss_pkg::COL_W-1:0]     s_cell_column,
    input  wire logic [gss_pkg::COL_W-1:0]     s_cell_row,
    input  wire logic                          s_cell_value,
    input  wire logic [gss_pkg::RND_W-1:0]     s_random_word,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [gss_pkg::COL_W-1:0]          m_position,
    output logic                               m_end_of_cycle,
    output logic [gss_pkg::GRID_SIZE-1:0]      m_row_mask,
    output logic                               m_reset_pending,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gss_pkg::CFG_DAT_W-1:0] cfg_data
);
    import gss_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [OP_W-1:0]   op_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  row_reg;
    logic              val_reg;
    logic [RND_W-1:0]  rnd_reg;

    logic              out_valid_reg, out_valid_next;
    ph_res_t           res_reg;
    col_t              mask_reg;

    cfg_t              cfg_reg;
    logic              advance;
    ph_res_t           ph_res;
    col_t              mask_next;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (advance) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg.window_start  <= '0;
            cfg_reg.window_length <= LEN_W'(GRID_SIZE);
            cfg_reg.play_mode     <= MODE_FWD;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_START:  cfg_reg.window_start  <= cfg_data[COL_W-1:0];
                    CFG_LENGTH: cfg_reg.window_length <= cfg_data[LEN_W-1:0];
                    CFG_MODE:   cfg_reg.play_mode     <= cfg_data[MODE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_opcode;
            col_reg <= s_cell_column;
            row_reg <= s_cell_row;
            val_reg <= s_cell_value;
            rnd_reg <= s_random_word;
        end
        if (advance) begin
            res_reg  <= ph_res;
            mask_reg <= mask_next;
        end
    end

    gss_playhead u_playhead (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .opcode      (op_reg),
        .random_word (rnd_reg),
        .cfg         (cfg_reg),
        .res         (ph_res)
    );

    gss_grid u_grid (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .opcode      (op_reg),
        .cell_column (col_reg),
        .cell_row    (row_reg),
        .cell_value  (val_reg),
        .sel_column  (ph_res.position),
        .row_mask    (mask_next)
    );

    assign m_valid         = out_valid_reg;
    assign m_position      = res_reg.position;
    assign m_end_of_cycle  = res_reg.end_of_cycle;
    assign m_reset_pending = res_reg.reset_pending;
    assign m_row_mask      = mask_reg;

endmodule

`default_nettype wire

// ===== src/gss_grid.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gss_grid (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      step_en,
    input  wire logic [gss_pkg::OP_W-1:0]  opcode,
    input  wire logic [gss_pkg::COL_W-1:0] cell_column,
    input  wire logic [gss_pkg::COL_W-1:0] cell_row,
    input  wire logic                      cell_value,
    input  wire logic [gss_pkg::COL_W-1:0] sel_column,
    output logic [gss_pkg::GRID_SIZE-1:0]  row_mask
);
    import gss_pkg::*;

    col_t grid_reg  [GRID_SIZE];
    col_t grid_next [GRID_SIZE];
    col_t sel_col;

    always_comb begin
        for (int x = 0; x < GRID_SIZE; x++) begin
            grid_next[x] = grid_reg[x];
        end
        if (step_en) begin
            case (opcode)
                OP_CLEAR: begin
                    for (int x = 0; x < GRID_SIZE; x++) begin
                        grid_next[x] = '0;
                    end
                end
                OP_ROT: begin
                    for (int x = 0; x < GRID_SIZE; x++) begin
                        for (int y = 0; y < GRID_SIZE; y++) begin
                            grid_next[x][y] = grid_reg[y][GRID_SIZE-1-x];
                        end
                    end
                end
                OP_FLIP: begin
                    for (int x = 0; x < GRID_SIZE; x++) begin
                        for (int y = 0; y < GRID_SIZE; y++) begin
                            grid_next[x][y] = grid_reg[x][GRID_SIZE-1-y];
                        end
                    end
                end
                OP_SHIFT: begin
                    for (int x = 0; x < GRID_SIZE; x++) begin
                        grid_next[x] = {grid_reg[x][0], grid_reg[x][GRID_SIZE-1:1]};
                    end
                end
                OP_WRITE: begin
                    grid_next[cell_column][cell_row] = cell_value;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        for (int x = 0; x < GRID_SIZE; x++) begin
            if (!aresetn) begin
                grid_reg[x] <= '0;
            end else begin
                grid_reg[x] <= grid_next[x];
            end
        end
    end

    // bottom-up: mask bit b is row GRID_SIZE-1-b
    always_comb begin
        sel_col = grid_next[sel_column];
        for (int b = 0; b < GRID_SIZE; b++) begin
            row_mask[b] = sel_col[GRID_SIZE-1-b];
        end
    end

endmodule

`default_nettype wire

// ===== src/gss_playhead.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gss_playhead (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      step_en,
    input  wire logic [gss_pkg::OP_W-1:0]  opcode,
    input  wire logic [gss_pkg::RND_W-1:0] random_word,
    input  wire gss_pkg::cfg_t             cfg,
    output gss_pkg::ph_res_t               res
);
    import gss_pkg::*;

    logic [COL_W-1:0] playhead_reg, playhead_next;
    logic             fwd_reg, fwd_next;
    logic             wrapped_reg, wrapped_next;
    logic             pending_reg, pending_next;
    logic             eoc_reg, eoc_next;

    logic [MODE_W-1:0]      mode_eff;
    logic [LEN_W-1:0]       len;
    logic [LEN_W-1:0]       start_x;
    logic [LEN_W-1:0]       end_sum;
    logic [LEN_W-1:0]       rs_sum;
    logic [COL_W-1:0]       win_end;
    logic [COL_W-1:0]       restart_pos;
    logic [COL_W-1:0]       p0;
    logic                   wr_base;
    logic [LEN_W-1:0]       p_inc;
    logic [LEN_W-1:0]       p_dec;
    logic [LEN_W-1:0]       raw;
    logic                   wrap;
    logic                   fwd_clk;
    logic [RND_W+LEN_W-1:0] prod;
    logic [COL_W-1:0]       pos_clk;

    always_comb begin
        mode_eff = (cfg.play_mode > MODE_RND) ? MODE_RND : cfg.play_mode;
        if (cfg.window_length == '0) begin
            len = LEN_W'(1);
        end else if (cfg.window_length > LEN_W'(GRID_SIZE)) begin
            len = LEN_W'(GRID_SIZE);
        end else begin
            len = cfg.window_length;
        end
        start_x = {1'b0, cfg.window_start};
        end_sum = start_x + len - LEN_W'(1);
        rs_sum  = start_x + len;
        win_end = (end_sum > LEN_W'(GRID_SIZE - 1)) ? COL_W'(GRID_SIZE - 1) : end_sum[COL_W-1:0];
        restart_pos = (rs_sum > LEN_W'(GRID_SIZE - 1)) ? COL_W'(GRID_SIZE - 1)
                                                       : rs_sum[COL_W-1:0];

        if (pending_reg) begin
            p0 = (mode_eff == MODE_BWD || mode_eff == MODE_PP_B) ? cfg.window_start
                                                                 : restart_pos;
        end else begin
            p0 = playhead_reg;
        end
        wr_base = pending_reg ? 1'b0 : wrapped_reg;

        p_inc = {1'b0, p0} + LEN_W'(1);
        p_dec = (p0 == '0) ? '0 : {1'b0, p0} - LEN_W'(1);
        prod  = (RND_W+LEN_W)'(random_word) * (RND_W+LEN_W)'(len);

        raw     = p_inc;
        wrap    = 1'b0;
        fwd_clk = fwd_reg;
        case (mode_eff)
            MODE_FWD: begin
                fwd_clk = 1'b1;
                if (p_inc > {1'b0, win_end}) begin
                    raw  = start_x;
                    wrap = 1'b1;
                end
            end
            MODE_BWD: begin
                fwd_clk = 1'b0;
                raw     = (p0 > cfg.window_start) ? p_dec : {1'b0, win_end};
                wrap    = (raw == {1'b0, win_end});
            end
            MODE_PP_A, MODE_PP_B: begin
                if (fwd_reg) begin
                    if (p0 < win_end) begin
                        raw = p_inc;
                    end else begin
                        raw     = p_dec;
                        fwd_clk = 1'b0;
                        wrap    = 1'b1;
                    end
                end else begin
                    if (p0 > cfg.window_start) begin
                        raw = p_dec;
                    end else begin
                        raw     = p_inc;
                        fwd_clk = 1'b1;
                        wrap    = 1'b1;
                    end
                end
            end
            default: begin
                raw = start_x + prod[RND_W+LEN_W-1:RND_W];
            end
        endcase

        if (raw < start_x) begin
            pos_clk = cfg.window_start;
        end else if (raw > {1'b0, win_end}) begin
            pos_clk = win_end;
        end else begin
            pos_clk = raw[COL_W-1:0];
        end

        playhead_next = playhead_reg;
        fwd_next      = fwd_reg;
        wrapped_next  = wrapped_reg;
        pending_next  = pending_reg;
        eoc_next      = eoc_reg;
        if (step_en) begin
            case (opcode)
                OP_CLOCK: begin
                    playhead_next = pos_clk;
                    fwd_next      = fwd_clk;
                    wrapped_next  = wr_base | wrap;
                    pending_next  = 1'b0;
                    eoc_next      = wr_base & wrap;
                end
                OP_RESET: begin
                    pending_next = 1'b1;
                end
                default: begin
                end
            endcase
        end

        res.position      = playhead_next;
        res.end_of_cycle  = eoc_next;
        res.reset_pending = pending_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            playhead_reg <= '0;
            fwd_reg      <= 1'b1;
            wrapped_reg  <= 1'b0;
            pending_reg  <= 1'b1;
            eoc_reg      <= 1'b0;
        end else begin
            playhead_reg <= playhead_next;
            fwd_reg      <= fwd_next;
            wrapped_reg  <= wrapped_next;
            pending_reg  <= pending_next;
            eoc_reg      <= eoc_next;
        end
    end

endmodule

`default_nettype wire
